### hdl/huffman_code_bit_packer_unit_macros.svh
// Assertion macros for the Huffman code bit packer.
// Depends on nothing. The including module must have clock and reset signals.
`ifndef HUFFMAN_CODE_BIT_PACKER_UNIT_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
// Depends on nothing; the front, the back and the top use it by scoped names.
`timescale 1ns / 1ps

package hcbp_pkg;

   localparam int BYTE_BITS  = 8;
   localparam int SYM_BITS   = 8;
   localparam int WORD_BITS  = 16;
   localparam int LEN_BITS   = 5;
   localparam int MODE_BITS  = 2;
   localparam int TABLE_DEPTH = 256;
   // Bits left over between codes never reach a whole byte.
   localparam int FLUSH_BITS = BYTE_BITS - 1;
   // After a code that gives two bytes, up to fifteen bits wait for the second.
   localparam int PEND_BITS  = WORD_BITS - 1;
   localparam int CNT_BITS   = 4;
   localparam int ACC_BITS   = FLUSH_BITS + WORD_BITS;

   localparam logic [MODE_BITS-1:0] MODE_LOAD   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_ENCODE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_FLUSH  = 2'd2;

   typedef struct packed {
      logic                 flush;
      logic [LEN_BITS-1:0]  len;
      logic [WORD_BITS-1:0] word;
   } cmd_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic owed;
   } back_status_type;

endpackage

### hdl/hcbp_fifo.sv
// Small register queue, first in first out, used between the stages.
// Depends on nothing. DEPTH must be a power of two, at least 2.
`timescale 1ns / 1ps

module hcbp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [AW:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW:0]      rd_ptr_ff, rd_ptr_in;
   logic             do_push, do_pop;

   assign empty   = (wr_ptr_ff == rd_ptr_ff);
   assign full    = (wr_ptr_ff[AW] != rd_ptr_ff[AW]) &&
                    (wr_ptr_ff[AW-1:0] == rd_ptr_ff[AW-1:0]);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = store_ff[rd_ptr_ff[AW-1:0]];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff[AW-1:0]] <= wr_data;
      end
   end

endmodule

### hdl/hcbp_front.sv
// Front part: accepts words, keeps the code table and turns words into commands.
// Depends on hcbp_pkg.
`timescale 1ns / 1ps

module hcbp_front #(
   parameter int MAX_CODE_LEN = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [hcbp_pkg::MODE_BITS-1:0]      req_mode,
   input  logic [hcbp_pkg::SYM_BITS-1:0]       req_symbol,
   input  logic [hcbp_pkg::WORD_BITS-1:0]      req_code_bits,
   input  logic [hcbp_pkg::LEN_BITS-1:0]       req_code_length,
   output logic                                cmd_push,
   output hcbp_pkg::cmd_type                   cmd_data,
   input  logic                                cmd_full
);

   localparam int LEN_LIMIT = (MAX_CODE_LEN < hcbp_pkg::WORD_BITS) ?
                              MAX_CODE_LEN : hcbp_pkg::WORD_BITS;
   localparam logic [hcbp_pkg::LEN_BITS-1:0] LEN_LIMIT_L = LEN_LIMIT[hcbp_pkg::LEN_BITS-1:0];

   logic [hcbp_pkg::WORD_BITS-1:0] word_mem [hcbp_pkg::TABLE_DEPTH];
   logic [hcbp_pkg::LEN_BITS-1:0]  len_mem  [hcbp_pkg::TABLE_DEPTH];
   logic [hcbp_pkg::TABLE_DEPTH-1:0] known_ff;

   logic                           s1_valid_ff, s1_valid_in;
   logic [hcbp_pkg::MODE_BITS-1:0] s1_mode_ff;
   logic [hcbp_pkg::WORD_BITS-1:0] s1_word_ff;
   logic [hcbp_pkg::LEN_BITS-1:0]  s1_len_ff;
   logic                           s1_known_ff;

   logic                           accept, is_load, needs_push, advance;
   logic [hcbp_pkg::LEN_BITS-1:0]  sat_len, len_eff;

   assign accept  = push && !full;
   assign is_load = (req_mode == hcbp_pkg::MODE_LOAD);
   assign sat_len = (req_code_length > LEN_LIMIT_L) ? LEN_LIMIT_L : req_code_length;

   // An entry that was never loaded has no code.
   assign len_eff = s1_known_ff ? s1_len_ff : '0;

   assign needs_push = s1_valid_ff &&
                       (((s1_mode_ff == hcbp_pkg::MODE_ENCODE) && (len_eff != '0)) ||
                        (s1_mode_ff == hcbp_pkg::MODE_FLUSH));
   assign advance  = !needs_push || !cmd_full;
   assign full     = s1_valid_ff && !advance;
   assign cmd_push = needs_push && !cmd_full;

   always_comb begin
      cmd_data.flush = (s1_mode_ff == hcbp_pkg::MODE_FLUSH);
      cmd_data.len   = len_eff;
      cmd_data.word  = s1_word_ff & ~({hcbp_pkg::WORD_BITS{1'b1}} << len_eff);
      s1_valid_in    = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         known_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept && is_load) begin
            known_ff[req_symbol] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff  <= req_mode;
         s1_word_ff  <= word_mem[req_symbol];
         s1_len_ff   <= len_mem[req_symbol];
         s1_known_ff <= known_ff[req_symbol];
      end
      if (accept && is_load) begin
         word_mem[req_symbol] <= req_code_bits;
         len_mem[req_symbol]  <= sat_len;
      end
   end

endmodule

### hdl/hcbp_back.sv
// Back part: appends codes to pending bits; emits a byte a cycle unless out_full.
// Depends on hcbp_pkg.
`timescale 1ns / 1ps

module hcbp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   input  hcbp_pkg::cmd_type          cmd_data,
   output logic                       cmd_pop,
   output hcbp_pkg::rsp_type          out_data,
   input  logic                       out_full,
   output hcbp_pkg::back_status_type  status
);

   localparam int ACC   = hcbp_pkg::ACC_BITS;
   localparam int PEND  = hcbp_pkg::PEND_BITS;
   localparam int FL    = hcbp_pkg::FLUSH_BITS;
   localparam int CNT   = hcbp_pkg::CNT_BITS;
   localparam int BYTE  = hcbp_pkg::BYTE_BITS;
   localparam int LEN   = hcbp_pkg::LEN_BITS;

   logic [PEND-1:0] bits_ff, bits_in;
   logic [CNT-1:0]  cnt_ff, cnt_in;
   logic            owed_ff, owed_in;

   logic [ACC-1:0]  acc;
   logic [LEN-1:0]  sum, rem_full;
   logic [CNT-1:0]  rem;
   logic            push;

   always_comb begin
      acc      = (ACC'(bits_ff[FL-1:0]) << cmd_data.len) | ACC'(cmd_data.word);
      sum      = {1'b0, cnt_ff} + cmd_data.len;
      rem_full = sum - LEN'(BYTE);
      rem      = rem_full[CNT-1:0];

      bits_in  = bits_ff;
      cnt_in   = cnt_ff;
      owed_in  = owed_ff;
      push     = 1'b0;
      cmd_pop  = 1'b0;
      out_data.out_byte = BYTE'(bits_ff >> cnt_ff[CNT-2:0]);
      out_data.last     = 1'b1;

      if (owed_ff) begin
         // Second byte of a long code; what remains is under one byte.
         if (!out_full) begin
            push    = 1'b1;
            bits_in = bits_ff & ~({PEND{1'b1}} << cnt_ff[CNT-2:0]);
            cnt_in  = {1'b0, cnt_ff[CNT-2:0]};
            owed_in = 1'b0;
         end
      end else if (cmd_valid && !out_full) begin
         cmd_pop = 1'b1;
         if (cmd_data.flush) begin
            out_data.out_byte = BYTE'(bits_ff[FL-1:0]) << (CNT'(BYTE) - cnt_ff);
            push    = (cnt_ff != '0);
            bits_in = '0;
            cnt_in  = '0;
         end else if (sum >= LEN'(BYTE)) begin
            out_data.out_byte = BYTE'(acc >> rem_full);
            out_data.last     = (sum < LEN'(2 * BYTE));
            push    = 1'b1;
            bits_in = PEND'(acc & ~({ACC{1'b1}} << rem));
            cnt_in  = rem;
            owed_in = (sum >= LEN'(2 * BYTE));
         end else begin
            bits_in = PEND'(acc);
            cnt_in  = sum[CNT-1:0];
         end
      end

      status.push = push;
      status.owed = owed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
         cnt_ff  <= '0;
         owed_ff <= 1'b0;
      end else begin
         bits_ff <= bits_in;
         cnt_ff  <= cnt_in;
         owed_ff <= owed_in;
      end
   end

endmodule

### hdl/huffman_code_bit_packer_unit.sv
// Huffman code bit packer: an accepted item passes the front stage register, the
// command queue and the response queue before its first result word is shown.
// The front takes one word every cycle while full is low; the back packer takes no
// new item while the second byte of a code that completes two bytes is owed.
// Synchronous active-high reset empties both queues and the pending bits and marks
// every table entry as having no code; no clearing pass is needed.
`timescale 1ns / 1ps
`include "huffman_code_bit_packer_unit_macros.svh"

module huffman_code_bit_packer_unit #(
   parameter int MAX_CODE_LEN    = 16,
   parameter int CMD_QUEUE_DEPTH = 2,
   parameter int RSP_QUEUE_DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request side: a word is taken when push is high and full is low.
   input  logic                           push,
   output logic                           full,
   input  logic [hcbp_pkg::MODE_BITS-1:0] req_mode,
   input  logic [hcbp_pkg::SYM_BITS-1:0]  req_symbol,
   input  logic [hcbp_pkg::WORD_BITS-1:0] req_code_bits,
   input  logic [hcbp_pkg::LEN_BITS-1:0]  req_code_length,
   // Response side: the oldest word is shown while empty is low.
   output logic                           empty,
   input  logic                           pop,
   output logic [hcbp_pkg::BYTE_BITS-1:0] rsp_out_byte,
   output logic                           rsp_last_of_run
);

   localparam int CMD_W = $bits(hcbp_pkg::cmd_type);
   localparam int RSP_W = $bits(hcbp_pkg::rsp_type);

   // Front to command queue.
   logic                       cmd_push;
   hcbp_pkg::cmd_type          cmd_wr;
   logic                       cmd_full;
   // Command queue to back.
   logic [CMD_W-1:0]           cmd_rd_bits;
   hcbp_pkg::cmd_type          cmd_rd;
   logic                       cmd_empty;
   logic                       cmd_pop;
   // Back to response queue.
   hcbp_pkg::rsp_type          rsp_wr;
   hcbp_pkg::back_status_type  back_status;
   logic                       rsp_full_w;
   logic [RSP_W-1:0]           rsp_rd_bits;
   hcbp_pkg::rsp_type          rsp_rd;

   // The front reads the code table in the cycle of acceptance, so a load is
   // visible to an encode that arrives in the very next cycle.
   hcbp_front #(
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_mode        (req_mode),
      .req_symbol      (req_symbol),
      .req_code_bits   (req_code_bits),
      .req_code_length (req_code_length),
      .cmd_push        (cmd_push),
      .cmd_data        (cmd_wr),
      .cmd_full        (cmd_full)
   );

   // The command queue lets the front keep taking words while the packer is
   // busy with a code that yields two bytes.
   hcbp_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (CMD_W'(cmd_wr)),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd_bits),
      .empty   (cmd_empty)
   );

   assign cmd_rd = hcbp_pkg::cmd_type'(cmd_rd_bits);

   hcbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd_data  (cmd_rd),
      .cmd_pop   (cmd_pop),
      .out_data  (rsp_wr),
      .out_full  (rsp_full_w),
      .status    (back_status)
   );

   // The response queue parts the packer from the consumer, so a stalled
   // consumer does not stop the packer until the queue fills.
   hcbp_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (back_status.push),
      .wr_data (RSP_W'(rsp_wr)),
      .full    (rsp_full_w),
      .pop     (pop),
      .rd_data (rsp_rd_bits),
      .empty   (empty)
   );

   assign rsp_rd          = hcbp_pkg::rsp_type'(rsp_rd_bits);
   assign rsp_out_byte    = rsp_rd.out_byte;
   assign rsp_last_of_run = rsp_rd.last;

   // The packer must never push into a full response queue, nor the front into
   // a full command queue, and an owed second byte goes out at the first chance.
   `HCBP_ASSERT_NOW(a_rsp_no_overflow, back_status.push, !rsp_full_w, "response queue overrun")
   `HCBP_ASSERT_NOW(a_cmd_no_overflow, cmd_push, !cmd_full, "command queue overrun")
   `HCBP_ASSERT_NEXT(a_owed_drains, back_status.owed && !rsp_full_w, !back_status.owed, "second byte stuck")

endmodule
